[hdl/itb_pkg.sv]
package itb_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned SlotW = 7;
  localparam int unsigned TagW  = 16;
  localparam int unsigned TimeW = 32;

  // Link terminator, never a valid slot
  localparam logic [SlotW-1:0] Nil = 7'h7F;

  // Default sizing and per-drain record limit
  localparam int unsigned DefSlots   = 64;
  localparam int unsigned DefTagBits = 16;
  localparam int unsigned DrainMax   = 64;
  localparam int unsigned CntW       = $clog2(DrainMax + 1);

  // Search granule of the free-slot tree
  localparam int unsigned GrpSize = 8;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdEnd   = 2'd1,
    CmdDrain = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StReply,
    StStartPick,
    StStartLink,
    StEndCheck,
    StDrainEmit
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [TagW-1:0]  event_tag;
    logic [TagW-1:0]  task_tag;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [SlotW-1:0] slot_out;
    logic [TagW-1:0]  rec_task_tag;
    logic [TagW-1:0]  rec_event_tag;
    logic [TimeW-1:0] rec_start_us;
    logic [TimeW-1:0] rec_elapsed_us;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
  } found_t;

endpackage

[hdl/interval_trace_buffer_core.sv]
// Interval trace buffer: a table of SLOTS records kept in one synchronous
// memory (tags, start time, end time, next link) with used and ended flags in
// flip-flops, so the table is empty right after reset with no clearing pass.
// A start samples a group search of the free flags on the transfer, then
// writes the record and, unless the list is empty, reads the old tail and
// writes its link; an end reads the record on the transfer, then compares the
// tag and writes back; a drain reads the head on the transfer and then delivers
// one record per cycle while the output is not stalled, following the next
// links through the memory read port, stopping at the first unfinished record
// or after 64 records. Commands that change nothing get an empty result.
// Results leave through an output register, so a new command is taken while
// the previous result still waits; a stalled output holds the sequencer.
module interval_trace_buffer_core #(
  parameter int unsigned SLOTS    = itb_pkg::DefSlots,
  parameter int unsigned TAG_BITS = itb_pkg::DefTagBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  itb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output itb_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int unsigned AddrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KeepW = (TAG_BITS < itb_pkg::TagW) ? TAG_BITS : itb_pkg::TagW;
  localparam logic [itb_pkg::SlotW:0] SlotsLim = (itb_pkg::SlotW + 1)'(SLOTS);

  typedef struct packed {
    logic [KeepW-1:0]          evt;
    logic [KeepW-1:0]          tsk;
    logic [itb_pkg::TimeW-1:0] start_us;
    logic [itb_pkg::TimeW-1:0] end_us;
    logic [itb_pkg::SlotW-1:0] next;
  } rec_word_t;

  itb_pkg::state_e    state_q, state_d;
  itb_pkg::in_item_t  in_q, in_d;
  itb_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               enable_q;
  logic [SLOTS-1:0]   used_q, used_d;
  logic [SLOTS-1:0]   ended_q, ended_d;
  logic [itb_pkg::SlotW-1:0] head_q, head_d;
  logic [itb_pkg::SlotW-1:0] tail_q, tail_d;
  logic [itb_pkg::SlotW-1:0] link_q, link_d;
  logic [itb_pkg::CntW-1:0]  cnt_q, cnt_d;

  rec_word_t        mem_q [SLOTS];
  rec_word_t        rd_q;
  rec_word_t        mem_wdata;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  logic             accept, out_free, search_go;
  logic             slot_in_range, head_ready, next_ready, more;
  itb_pkg::found_t  found;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == itb_pkg::StIdle);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign search_go = accept && enable_q &&
                     (in_data_i.cmd == itb_pkg::CmdStart);

  // Lowest free slot, registered over two levels
  itb_free_search #(
    .SLOTS (SLOTS)
  ) u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (search_go),
    .used_i   (used_q),
    .found_o  (found)
  );

  // Range checks on slot numbers taken from the command and the links
  assign slot_in_range = ({1'b0, in_data_i.slot} < SlotsLim);
  assign head_ready    = ({1'b0, head_q} < SlotsLim) && ended_q[head_q[AddrW-1:0]];
  assign next_ready    = ({1'b0, rd_q.next} < SlotsLim) &&
                         used_q[rd_q.next[AddrW-1:0]] && ended_q[rd_q.next[AddrW-1:0]];
  assign more          = (cnt_q != itb_pkg::CntW'(itb_pkg::DrainMax - 1)) && next_ready;

  // Record memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itb_pkg::StIdle;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      ended_q     <= '0;
      head_q      <= itb_pkg::Nil;
      tail_q      <= itb_pkg::Nil;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      ended_q     <= ended_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    out_q  <= out_d;
    link_q <= link_d;
  end

  // Sequencer: read, modify and write back one record per step
  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    used_d      = used_q;
    ended_d     = ended_q;
    head_d      = head_q;
    tail_d      = tail_q;
    link_d      = link_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = rd_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_q)
      itb_pkg::StIdle: begin
        if (accept) begin
          in_d  = in_data_i;
          cnt_d = '0;
          case (in_data_i.cmd)
            itb_pkg::CmdStart: begin
              state_d = enable_q ? itb_pkg::StStartPick : itb_pkg::StReply;
            end
            itb_pkg::CmdEnd: begin
              if (enable_q && slot_in_range && used_q[in_data_i.slot[AddrW-1:0]] &&
                  !ended_q[in_data_i.slot[AddrW-1:0]]) begin
                mem_re    = 1'b1;
                mem_raddr = in_data_i.slot[AddrW-1:0];
                state_d   = itb_pkg::StEndCheck;
              end else begin
                state_d = itb_pkg::StReply;
              end
            end
            itb_pkg::CmdDrain: begin
              if (head_ready) begin
                mem_re    = 1'b1;
                mem_raddr = head_q[AddrW-1:0];
                state_d   = itb_pkg::StDrainEmit;
              end else begin
                state_d = itb_pkg::StReply;
              end
            end
            default: begin
              state_d = itb_pkg::StReply;
            end
          endcase
        end
      end

      // Answer with an empty result
      itb_pkg::StReply: begin
        if (out_free) begin
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = itb_pkg::StIdle;
        end
      end

      // Claim the free slot and write its record
      itb_pkg::StStartPick: begin
        if (out_free) begin
          if (!found.valid) begin
            out_d       = '0;
            out_d.last  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = itb_pkg::StIdle;
          end else begin
            mem_we             = 1'b1;
            mem_waddr          = found.slot[AddrW-1:0];
            mem_wdata.evt      = in_q.event_tag[KeepW-1:0];
            mem_wdata.tsk      = in_q.task_tag[KeepW-1:0];
            mem_wdata.start_us = in_q.now_us;
            mem_wdata.end_us   = '0;
            mem_wdata.next     = itb_pkg::Nil;
            used_d[found.slot[AddrW-1:0]]  = 1'b1;
            ended_d[found.slot[AddrW-1:0]] = 1'b0;
            if ({1'b0, tail_q} < SlotsLim) begin
              // Fetch the old tail to append behind it
              mem_re    = 1'b1;
              mem_raddr = tail_q[AddrW-1:0];
              link_d    = found.slot;
              state_d   = itb_pkg::StStartLink;
            end else begin
              head_d         = found.slot;
              tail_d         = found.slot;
              out_d          = '0;
              out_d.ok       = 1'b1;
              out_d.slot_out = found.slot;
              out_d.last     = 1'b1;
              out_valid_d    = 1'b1;
              state_d        = itb_pkg::StIdle;
            end
          end
        end
      end

      // Point the old tail at the new record
      itb_pkg::StStartLink: begin
        if (out_free) begin
          mem_we         = 1'b1;
          mem_waddr      = tail_q[AddrW-1:0];
          mem_wdata      = rd_q;
          mem_wdata.next = link_q;
          tail_d         = link_q;
          out_d          = '0;
          out_d.ok       = 1'b1;
          out_d.slot_out = link_q;
          out_d.last     = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = itb_pkg::StIdle;
        end
      end

      // Stamp the end time when the event tag matches
      itb_pkg::StEndCheck: begin
        if (out_free) begin
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = itb_pkg::StIdle;
          if (rd_q.evt == in_q.event_tag[KeepW-1:0]) begin
            mem_we           = 1'b1;
            mem_waddr        = in_q.slot[AddrW-1:0];
            mem_wdata        = rd_q;
            mem_wdata.end_us = in_q.now_us;
            ended_d[in_q.slot[AddrW-1:0]] = 1'b1;
            out_d.ok         = 1'b1;
          end
        end
      end

      // Emit the head record, free it and advance along the list
      itb_pkg::StDrainEmit: begin
        if (out_free) begin
          out_d.ok             = 1'b1;
          out_d.slot_out       = head_q;
          out_d.rec_task_tag   = itb_pkg::TagW'(rd_q.tsk);
          out_d.rec_event_tag  = itb_pkg::TagW'(rd_q.evt);
          out_d.rec_start_us   = rd_q.start_us;
          out_d.rec_elapsed_us = rd_q.end_us - rd_q.start_us;
          out_d.last           = !more;
          out_valid_d          = 1'b1;
          used_d[head_q[AddrW-1:0]]  = 1'b0;
          ended_d[head_q[AddrW-1:0]] = 1'b0;
          head_d = rd_q.next;
          if (!({1'b0, rd_q.next} < SlotsLim)) begin
            tail_d = itb_pkg::Nil;
          end
          cnt_d = cnt_q + itb_pkg::CntW'(1);
          if (more) begin
            mem_re    = 1'b1;
            mem_raddr = rd_q.next[AddrW-1:0];
          end else begin
            state_d = itb_pkg::StIdle;
          end
        end
      end

      default: begin
        state_d = itb_pkg::StIdle;
      end
    endcase
  end

endmodule

[hdl/itb_free_search.sv]
module itb_free_search #(
  parameter int unsigned SLOTS = itb_pkg::DefSlots
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sample_i,
  input  logic [SLOTS-1:0]  used_i,
  output itb_pkg::found_t   found_o
);

  localparam int unsigned Groups = (SLOTS + itb_pkg::GrpSize - 1) / itb_pkg::GrpSize;
  localparam int unsigned PadW   = Groups * itb_pkg::GrpSize;
  localparam int unsigned IdxW   = $clog2(itb_pkg::GrpSize);

  logic [SLOTS-1:0]  free_bits;
  logic [PadW-1:0]   free_pad;
  logic [Groups-1:0] grp_any_d, grp_any_q;
  logic [IdxW-1:0]   grp_idx_d [Groups];
  logic [IdxW-1:0]   grp_idx_q [Groups];

  // Slots past the table never count as free
  assign free_bits = ~used_i;
  assign free_pad  = PadW'(free_bits);

  // First level: lowest free slot inside each group
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_any_d[g] = |free_pad[g*itb_pkg::GrpSize +: itb_pkg::GrpSize];
      grp_idx_d[g] = '0;
      for (int b = itb_pkg::GrpSize - 1; b >= 0; b--) begin
        if (free_pad[g*itb_pkg::GrpSize + b]) begin
          grp_idx_d[g] = IdxW'(b);
        end
      end
    end
  end

  // Hold the group results for the second level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      for (int g = 0; g < Groups; g++) begin
        grp_idx_q[g] <= '0;
      end
    end else if (sample_i) begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < Groups; g++) begin
        grp_idx_q[g] <= grp_idx_d[g];
      end
    end
  end

  // Second level: lowest group that has a free slot
  always_comb begin
    found_o = '0;
    for (int g = Groups - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_o.valid = 1'b1;
        found_o.slot  = itb_pkg::SlotW'(g * itb_pkg::GrpSize) |
                        itb_pkg::SlotW'(grp_idx_q[g]);
      end
    end
  end

endmodule
